[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

[rtl/core/polst_pkg.sv]
package polst_pkg;

    // Store geometry.
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths.
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int ST_W   = 2;
    localparam int FPOS_W = 5;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_EMPTY  = 3'd4,
        OP_DUMP   = 3'd5
    } t_op;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    // One result word.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              found;
        logic [FPOS_W-1:0] fpos;
        logic              list_empty;
        logic [VAL_W-1:0]  dval;
        logic              dvalid;
        logic              last;
    } t_res;

    // Request to the value store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

[rtl/core/positional_ordered_list_engine_top.sv]
// Positional ordered list engine.
// Holds an ordered list of up to 32 signed 32-bit values. Each input word on the
// i_in_valid / o_in_ready channel is one operation: append, insert at a position,
// remove at a position, search for the first equal value, empty query or dump.
// Results leave on the o_out_valid / i_out_ready channel through one output register;
// every operation gives one word, a dump gives one word per entry (one word when the
// list is empty), and o_last marks the final word of each operation.
// One operation is worked at a time; o_in_ready is high only while no operation is
// under way, and the next word is taken in the cycle after the last word is loaded.
// Append, insert at the end, removal of the last entry, empty query, unused opcode,
// bad position and full go straight to the result word. Other inserts walk down from
// the tail, moving each entry up by one, then write the value; remove walks up from
// the position, moving each entry down by one; search reads from the head until a hit
// or the list end; dump emits one entry a cycle while the output is not stalled. The
// store has one read and one write port, so each step moves or examines one entry.
// A stall on the output holds the output register and freezes the sequencer at the
// word that is waiting; nothing is lost. Synchronous reset empties the list; the
// stored values themselves are not cleared, as no entry beyond the count is read.
module positional_ordered_list_engine_top
    import polst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [VAL_W-1:0]  i_item_value,
    input  logic [POS_W-1:0]  i_item_position,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic              o_found,
    output logic [FPOS_W-1:0] o_found_position,
    output logic              o_list_empty,
    output logic [VAL_W-1:0]  o_dump_value,
    output logic              o_dump_valid,
    output logic              o_last
);

    t_mem_req         mem_req;
    logic [VAL_W-1:0] mem_rdata;
    t_res             res;
    logic             res_load;
    logic             can_load;
    logic             r_out_valid;
    t_res             r_out;

    polst_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    polst_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_position (i_item_position),
        .i_can_load      (can_load),
        .o_res_load      (res_load),
        .o_res           (res),
        .o_mem           (mem_req),
        .i_rdata         (mem_rdata)
    );

    // The output register takes a new word when empty or being emptied.
    assign can_load = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found          = r_out.found;
    assign o_found_position = r_out.fpos;
    assign o_list_empty     = r_out.list_empty;
    assign o_dump_value     = r_out.dval;
    assign o_dump_valid     = r_out.dvalid;
    assign o_last           = r_out.last;

endmodule

[rtl/core/polst_ram.sv]
module polst_ram
    import polst_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // One read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/polst_seq.sv]
`include "assert_macros.svh"

module polst_seq
    import polst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [VAL_W-1:0]  i_item_value,
    input  logic [POS_W-1:0]  i_item_position,
    input  logic              i_can_load,
    output logic              o_res_load,
    output t_res              o_res,
    output t_mem_req          o_mem,
    input  logic [VAL_W-1:0]  i_rdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INS    = 7'b0000010,
        S_PUT    = 7'b0000100,
        S_REM    = 7'b0001000,
        S_SEARCH = 7'b0010000,
        S_DUMP   = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [ST_W-1:0]   r_res_status, n_res_status;
    logic              r_res_found, n_res_found;
    logic [FPOS_W-1:0] r_res_fpos, n_res_fpos;

    logic             accept;
    logic             full;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] pos_cnt;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] idx_m2;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] idx_p2;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign pos_ext    = CMP_W'(i_item_position);
    assign cnt_ext    = CMP_W'(r_count);
    assign pos_cnt    = CNT_W'(i_item_position);
    assign cnt_m1     = r_count - 1'b1;
    assign idx_m1     = r_idx - 1'b1;
    assign idx_m2     = r_idx - CNT_W'(2);
    assign idx_p1     = r_idx + 1'b1;
    assign idx_p2     = r_idx + CNT_W'(2);

    // Sequencer: each step moves, compares or emits one entry through the store.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_fpos   = r_res_fpos;
        o_mem        = '0;
        o_mem.waddr  = r_idx[ADDR_W-1:0];
        o_res        = '0;
        o_res_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val        = i_item_value;
                    n_res_status = ST_OK;
                    n_res_found  = 1'b0;
                    n_res_fpos   = '0;
                    n_state      = S_FIN;
                    case (t_op'(i_opcode))
                        OP_APPEND: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_count[ADDR_W-1:0];
                                o_mem.wdata = i_item_value;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                n_res_status = ST_BADPOS;
                            end else if (full) begin
                                n_res_status = ST_FULL;
                            end else if (pos_ext == cnt_ext) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_count[ADDR_W-1:0];
                                o_mem.wdata = i_item_value;
                                n_count     = r_count + 1'b1;
                            end else begin
                                // Open a gap: walk down from the tail.
                                o_mem.re    = 1'b1;
                                o_mem.raddr = cnt_m1[ADDR_W-1:0];
                                n_idx       = r_count;
                                n_pos       = pos_cnt;
                                n_state     = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_res_status = ST_BADPOS;
                            end else if (pos_ext == CMP_W'(cnt_m1)) begin
                                n_count = cnt_m1;
                            end else begin
                                // Close the gap: walk up from the position.
                                o_mem.re    = 1'b1;
                                o_mem.raddr = ADDR_W'(pos_cnt + 1'b1);
                                n_idx       = pos_cnt;
                                n_state     = S_REM;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count != '0) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SEARCH;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = i_rdata;
                n_idx       = idx_m1;
                if (idx_m1 == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = idx_m2[ADDR_W-1:0];
                end
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = r_val;
                n_count     = r_count + 1'b1;
                n_state     = S_FIN;
            end
            S_REM: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = i_rdata;
                if (idx_p2 < r_count) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = idx_p2[ADDR_W-1:0];
                    n_idx       = idx_p1;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_FIN;
                end
            end
            S_SEARCH: begin
                if (i_rdata == r_val) begin
                    n_res_found = 1'b1;
                    n_res_fpos  = FPOS_W'(r_idx);
                    n_state     = S_FIN;
                end else if (idx_p1 == r_count) begin
                    n_state = S_FIN;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = idx_p1[ADDR_W-1:0];
                    n_idx       = idx_p1;
                end
            end
            S_DUMP: begin
                // The next entry is fetched in the same cycle the current one leaves.
                if (i_can_load) begin
                    o_res_load   = 1'b1;
                    o_res.dval   = i_rdata;
                    o_res.dvalid = 1'b1;
                    o_res.last   = (idx_p1 == r_count);
                    if (idx_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = idx_p1[ADDR_W-1:0];
                        n_idx       = idx_p1;
                    end
                end
            end
            S_FIN: begin
                if (i_can_load) begin
                    o_res_load       = 1'b1;
                    o_res.status     = r_res_status;
                    o_res.found      = r_res_found;
                    o_res.fpos       = r_res_fpos;
                    o_res.list_empty = (r_count == '0);
                    o_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_fpos   <= n_res_fpos;
    end

    `ASSERT_CLK(a_count_bound, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_last_ends_op, o_res_load && o_res.last, r_state == S_IDLE, "last word did not end the operation")
    `ASSERT_CLK(a_walk_in_range, (r_state == S_SEARCH || r_state == S_DUMP) |-> (r_idx < r_count), "walk index past the list end")
    `ASSERT_CLK(a_insert_room, (r_state == S_INS || r_state == S_PUT) |-> (r_count < CNT_W'(CAPACITY)), "insert under way on a full list")

endmodule
